// ===== rtl/core/lpbm_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page buffer manager package
// Shared constants, action codes and the cell interface types.
// ----------------------------------------------------------------------------
package lpbm_pkg;

    // Pool size and derived widths.
    localparam int NUM_BUFFERS = 8;
    localparam int ID_W        = $clog2(NUM_BUFFERS);
    localparam int CMP_W       = (ID_W > 3) ? ID_W : 3;
    localparam int SUM_W       = $clog2(NUM_BUFFERS + 1);

    // Fixed field widths.
    localparam int REL_W   = 32;
    localparam int PAGE_W  = 31;
    localparam int FILE_W  = 8;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 4;
    localparam int COUNT_MAX = 15;

    // Operation codes carried by the action field.
    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_TOUCH  = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_RESET  = 2'd3
    } action_t;

    // Contents of one cell: which buffer sits at this LRU position, and its tag.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              valid;
        logic [REL_W-1:0]  rel;
        logic [PAGE_W-1:0] page;
        logic [FILE_W-1:0] file;
    } cell_data_t;

    // Per-cell update command for one execute cycle.
    typedef struct packed {
        logic shift;       // take the contents handed in from the newer side
        logic write_tag;   // assign a new page to this buffer
        logic write_file;  // refresh the stored file handle
        logic clear;       // invalidate this buffer
    } cell_cmd_t;

endpackage

// ===== rtl/core/lpbm_cell.sv =====
// ----------------------------------------------------------------------------
// LRU page buffer manager cell
// One position of the recency chain: holds a buffer id and its tag, compares
// the tag against the request and takes its newer neighbor's contents on shift.
// ----------------------------------------------------------------------------
module lpbm_cell
    import lpbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ID_W-1:0]   home_id,
    input  cell_cmd_t         cmd,
    input  cell_data_t        shift_in,
    input  logic [REL_W-1:0]  rel,
    input  logic [PAGE_W-1:0] page,
    input  logic [FILE_W-1:0] fh,
    output cell_data_t        data,
    output logic              rel_match,
    output logic              page_match
);

    logic [ID_W-1:0]   id_reg;
    logic              valid_reg;
    logic [REL_W-1:0]  rel_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [FILE_W-1:0] file_reg;

    // Control part: buffer id at this position and its valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg    <= home_id;
            valid_reg <= 1'b0;
        end
        else if (cmd.shift)
        begin
            id_reg    <= shift_in.id;
            valid_reg <= shift_in.valid;
        end
        else if (cmd.write_tag)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd.clear)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Tag payload; only read behind the valid bit, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            rel_reg  <= shift_in.rel;
            page_reg <= shift_in.page;
            file_reg <= shift_in.file;
        end
        else if (cmd.write_tag)
        begin
            rel_reg  <= rel;
            page_reg <= page;
            file_reg <= fh;
        end
        else if (cmd.write_file)
        begin
            file_reg <= fh;
        end
    end

    // Tag comparison against the current request.
    assign rel_match  = valid_reg && (rel_reg == rel);
    assign page_match = (page_reg == page);

    assign data.id    = id_reg;
    assign data.valid = valid_reg;
    assign data.rel   = rel_reg;
    assign data.page  = page_reg;
    assign data.file  = file_reg;

endmodule

// ===== rtl/core/lru_page_buffer_manager.sv =====
// ----------------------------------------------------------------------------
// LRU page buffer manager
// Pool of page buffers held in a chain of cells ordered most recent first,
// with lookup/assign, touch to head, flush relation and reset entry.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Beat contents
//  in       input      in_valid/in_ready    action, relation_id, page_id,
//                                           file_handle, relation_closed,
//                                           entry_index, reset_entries,
//                                           writeback_ok
//  out      output     out_valid/out_ready  slot, slot_valid, hit, evicted,
//                                           flush_failed, match_count
//
// Each item is captured in ST_IDLE; in ST_EXEC all cells then compare in
// parallel and the chain is updated.
// One result beat per input beat, in order.
// A stalled output holds the execute cycle; the input is taken again as soon
// as the previous item has executed, while its result may still wait.
// Reset puts buffer k at chain position k with every buffer invalid.
// ----------------------------------------------------------------------------
module lru_page_buffer_manager
    import lpbm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [REL_W-1:0]    relation_id,
    input  logic [PAGE_W-1:0]   page_id,
    input  logic [FILE_W-1:0]   file_handle,
    input  logic                relation_closed,
    input  logic [2:0]          entry_index,
    input  logic                reset_entries,
    input  logic                writeback_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SLOT_W-1:0]   slot,
    output logic                slot_valid,
    output logic                hit,
    output logic                evicted,
    output logic                flush_failed,
    output logic [COUNT_W-1:0]  match_count
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;

    // Captured request.
    action_t           act_reg;
    logic [REL_W-1:0]  rel_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [FILE_W-1:0] fh_reg;
    logic              closed_reg;
    logic [2:0]        idx_reg;
    logic              do_reset_reg;
    logic              wb_ok_reg;

    // Registered result.
    logic               out_valid_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               slot_valid_reg;
    logic               hit_reg;
    logic               evicted_reg;
    logic               failed_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [SLOT_W-1:0]  slot_next;
    logic               slot_valid_next;
    logic               hit_next;
    logic               evicted_next;
    logic               failed_next;
    logic [COUNT_W-1:0] count_next;

    logic in_fire;
    logic exec_fire;

    cell_data_t cell_q    [NUM_BUFFERS];
    cell_data_t shift_src [NUM_BUFFERS];
    cell_cmd_t  cell_cmd  [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] rel_m;
    logic [NUM_BUFFERS-1:0] page_m;
    logic [NUM_BUFFERS-1:0] tag_m;
    logic [NUM_BUFFERS-1:0] idx_m;
    logic [NUM_BUFFERS-1:0] free_sel;
    logic [NUM_BUFFERS-1:0] shift_en;

    logic              idx_ok;
    logic              hit_any;
    logic              have_free;
    logic              idx_used;
    logic              rel_any;
    logic [ID_W-1:0]   hit_id;
    logic [ID_W-1:0]   free_id;
    logic [SUM_W-1:0]  rel_sum;
    cell_data_t        head_in;
    logic              seen_free;
    logic              above;

    assign in_fire   = in_valid && in_ready;
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == ST_IDLE);

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg      <= action_t'(action);
            rel_reg      <= relation_id;
            page_reg     <= page_id;
            fh_reg       <= file_handle;
            closed_reg   <= relation_closed;
            idx_reg      <= entry_index;
            do_reset_reg <= reset_entries;
            wb_ok_reg    <= writeback_ok;
        end
    end

    // Row of cells, position 0 is the most recent buffer.
    for (genvar k = 0; k < NUM_BUFFERS; k++)
    begin : g_cell
        lpbm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .home_id    (ID_W'(k)),
            .cmd        (cell_cmd[k]),
            .shift_in   (shift_src[k]),
            .rel        (rel_reg),
            .page       (page_reg),
            .fh         (fh_reg),
            .data       (cell_q[k]),
            .rel_match  (rel_m[k]),
            .page_match (page_m[k])
        );
        assign tag_m[k] = rel_m[k] && page_m[k];
        assign idx_m[k] = (CMP_W'(cell_q[k].id) == CMP_W'(idx_reg));
        if (k == 0)
        begin : g_head
            assign shift_src[k] = head_in;
        end
        else
        begin : g_body
            assign shift_src[k] = cell_q[k-1];
        end
    end

    assign idx_ok = ({29'd0, idx_reg} < 32'(NUM_BUFFERS));

    // Selections over the row: hit, free nearest the tail, indexed entry, counts.
    always_comb
    begin
        hit_any   = 1'b0;
        hit_id    = '0;
        have_free = 1'b0;
        free_id   = '0;
        free_sel  = '0;
        seen_free = 1'b0;
        idx_used  = 1'b0;
        rel_any   = 1'b0;
        rel_sum   = '0;
        head_in   = '0;
        shift_en  = '0;
        above     = 1'b0;
        for (int k = 0; k < NUM_BUFFERS; k++)
        begin
            if (tag_m[k])
            begin
                hit_any = 1'b1;
                hit_id  = hit_id | cell_q[k].id;
            end
            if (idx_m[k])
            begin
                idx_used = idx_used | cell_q[k].valid;
                head_in  = head_in | cell_q[k];
            end
            rel_any = rel_any | rel_m[k];
            rel_sum = rel_sum + SUM_W'(rel_m[k]);
        end
        for (int k = NUM_BUFFERS - 1; k >= 0; k--)
        begin
            if (!cell_q[k].valid && !seen_free)
            begin
                seen_free   = 1'b1;
                free_sel[k] = 1'b1;
                free_id     = cell_q[k].id;
            end
            above       = above | idx_m[k];
            shift_en[k] = above;
        end
        have_free = seen_free;
    end

    // Per-cell commands and the result of the executing item.
    always_comb
    begin
        for (int k = 0; k < NUM_BUFFERS; k++)
        begin
            cell_cmd[k] = '0;
        end
        slot_next       = '0;
        slot_valid_next = 1'b0;
        hit_next        = 1'b0;
        evicted_next    = 1'b0;
        failed_next     = 1'b0;
        count_next      = '0;
        if (exec_fire)
        begin
            unique case (act_reg)
                ACT_LOOKUP:
                begin
                    if (hit_any)
                    begin
                        for (int k = 0; k < NUM_BUFFERS; k++)
                        begin
                            cell_cmd[k].write_file = tag_m[k] && closed_reg;
                        end
                        slot_next       = SLOT_W'(CMP_W'(hit_id));
                        slot_valid_next = 1'b1;
                        hit_next        = 1'b1;
                    end
                    else if (have_free)
                    begin
                        for (int k = 0; k < NUM_BUFFERS; k++)
                        begin
                            cell_cmd[k].write_tag = free_sel[k];
                        end
                        slot_next       = SLOT_W'(CMP_W'(free_id));
                        slot_valid_next = 1'b1;
                    end
                    else if (wb_ok_reg)
                    begin
                        cell_cmd[NUM_BUFFERS-1].write_tag = 1'b1;
                        slot_next       = SLOT_W'(CMP_W'(cell_q[NUM_BUFFERS-1].id));
                        slot_valid_next = 1'b1;
                        evicted_next    = 1'b1;
                    end
                    else
                    begin
                        cell_cmd[NUM_BUFFERS-1].clear = 1'b1;
                        failed_next = 1'b1;
                    end
                end
                ACT_TOUCH:
                begin
                    if (idx_ok && !idx_m[0])
                    begin
                        for (int k = 0; k < NUM_BUFFERS; k++)
                        begin
                            cell_cmd[k].shift = shift_en[k];
                        end
                    end
                end
                ACT_FLUSH:
                begin
                    for (int k = 0; k < NUM_BUFFERS; k++)
                    begin
                        cell_cmd[k].clear = rel_m[k] && do_reset_reg;
                    end
                    failed_next = rel_any && !wb_ok_reg;
                    if (32'(rel_sum) > 32'(COUNT_MAX))
                    begin
                        count_next = COUNT_W'(COUNT_MAX);
                    end
                    else
                    begin
                        count_next = COUNT_W'(rel_sum);
                    end
                end
                ACT_RESET:
                begin
                    if (idx_ok)
                    begin
                        for (int k = 0; k < NUM_BUFFERS; k++)
                        begin
                            cell_cmd[k].clear = idx_m[k];
                        end
                        failed_next = idx_used && !wb_ok_reg;
                    end
                end
                default:
                begin
                    failed_next = 1'b0;
                end
            endcase
        end
    end

    // Sequencer with the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            slot_reg       <= '0;
            slot_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            evicted_reg    <= 1'b0;
            failed_reg     <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_EXEC;
                    end
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    if (exec_fire)
                    begin
                        state_reg      <= ST_IDLE;
                        out_valid_reg  <= 1'b1;
                        slot_reg       <= slot_next;
                        slot_valid_reg <= slot_valid_next;
                        hit_reg        <= hit_next;
                        evicted_reg    <= evicted_next;
                        failed_reg     <= failed_next;
                        count_reg      <= count_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot         = slot_reg;
    assign slot_valid   = slot_valid_reg;
    assign hit          = hit_reg;
    assign evicted      = evicted_reg;
    assign flush_failed = failed_reg;
    assign match_count  = count_reg;

    // The requested entry index matches at most one chain position while an item executes.
    a_idx_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $onehot0(idx_m))
        else $error("buffer id held by more than one cell");

    // A page is buffered at most once among valid buffers.
    a_tag_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tag_m))
        else $error("duplicate valid tag in the pool");

    // An executed item always leaves a result beat behind.
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid && (state_reg == ST_IDLE))
        else $error("executed item produced no result");

    // A hit and an eviction never come together, and a hit always carries a valid slot.
    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted) && (!hit || slot_valid))
        else $error("inconsistent lookup flags");

endmodule
